// ===== src/tss_pkg.sv =====
package tss_pkg;

    // Word field widths
    localparam int ACTION_W = 2;
    localparam int TERM_W   = 6;
    localparam int DATA_W   = 32;

    // Function select codes
    localparam logic [ACTION_W-1:0] ACT_SIN = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COS = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EXP = 2'd2;

    // pi/180 as unsigned Q0.32
    localparam logic signed [DATA_W-1:0] DEG_TO_RAD_Q32 = 32'sd74961321;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Quotient bits retired per divider cycle
    localparam int DIV_RADIX_BITS = 4;

    typedef struct packed {
        logic start;
        logic rad;
        logic negate_a;
    } t_md_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_md_rsp;

endpackage

// ===== src/tss_if.sv =====
interface tss_in_if;
    import tss_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [TERM_W-1:0]          term_count;
    logic signed [DATA_W-1:0]   argument;

    modport source (output valid, action, term_count, argument, input ready);
    modport sink   (input valid, action, term_count, argument, output ready);
endinterface

interface tss_out_if;
    import tss_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   series_sum;
    logic                       overflow_flag;

    modport source (output valid, series_sum, overflow_flag, input ready);
    modport sink   (input valid, series_sum, overflow_flag, output ready);
endinterface

// ===== src/tss_muldiv.sv =====
module tss_muldiv #(
    parameter int FRAC_BITS = 16,
    parameter int DIV_W     = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tss_pkg::t_md_req                   i_req,
    input  logic signed [tss_pkg::DATA_W-1:0]  i_op_a,
    input  logic signed [tss_pkg::DATA_W-1:0]  i_op_b,
    input  logic [DIV_W-1:0]                   i_divisor,
    output tss_pkg::t_md_rsp                   o_rsp,
    output logic signed [tss_pkg::DATA_W-1:0]  o_value
);
    import tss_pkg::*;

    localparam int PW    = 2 * DATA_W;
    localparam int QW    = PW - FRAC_BITS;
    localparam int STEPS = (QW + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int QP    = STEPS * DIV_RADIX_BITS;
    localparam int SW    = $clog2(STEPS);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_MUL  = 5'b00010,
        M_RND  = 5'b00100,
        M_DIV  = 5'b01000,
        M_SAT  = 5'b10000
    } t_md_state;

    t_md_state r_state, n_state;
    logic [DATA_W-1:0] r_mag_a, n_mag_a, r_mag_b, n_mag_b;
    logic r_neg, n_neg, r_rad, n_rad, r_done, n_done, r_sat, n_sat;
    logic [DIV_W-1:0] r_div, n_div;
    logic [PW-1:0] r_prod, n_prod, prod_c;
    logic [QP-1:0] r_quo, n_quo, quo_v;
    logic [DIV_W-1:0] r_rem, n_rem, rem_v;
    logic [DIV_W:0] rem_ext;
    logic [SW-1:0] r_cnt, n_cnt;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic a_neg, sat_c;

    assign prod_c = r_mag_a * r_mag_b;

    // Sign of the first operand after optional negation
    assign a_neg = i_req.negate_a ? (!i_op_a[DATA_W-1] && (i_op_a != '0))
                                  : i_op_a[DATA_W-1];

    // Overflow when the magnitude leaves the 32-bit signed range
    assign sat_c = (|r_quo[QP-1:DATA_W]) ||
                   (r_quo[DATA_W-1] && (!r_neg || (|r_quo[DATA_W-2:0])));

    always_comb begin
        n_state = r_state;
        n_mag_a = r_mag_a;
        n_mag_b = r_mag_b;
        n_neg   = r_neg;
        n_rad   = r_rad;
        n_div   = r_div;
        n_prod  = r_prod;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_value = r_value;
        n_sat   = r_sat;
        n_done  = 1'b0;
        rem_v   = r_rem;
        quo_v   = r_quo;
        rem_ext = '0;
        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_mag_a = i_op_a[DATA_W-1] ? DATA_W'(-i_op_a) : DATA_W'(i_op_a);
                    n_mag_b = i_op_b[DATA_W-1] ? DATA_W'(-i_op_b) : DATA_W'(i_op_b);
                    n_neg   = a_neg ^ i_op_b[DATA_W-1];
                    n_rad   = i_req.rad;
                    n_div   = i_divisor;
                    n_state = M_MUL;
                end
            end
            M_MUL: begin
                n_prod  = prod_c;
                n_state = M_RND;
            end
            M_RND: begin
                if (r_rad) begin
                    n_quo   = QP'((r_prod + (PW'(1) << (DATA_W - 1))) >> DATA_W);
                    n_state = M_SAT;
                end else begin
                    n_quo   = QP'((r_prod + (PW'(r_div) << (FRAC_BITS - 1))) >> FRAC_BITS);
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = M_DIV;
                end
            end
            M_DIV: begin
                // restoring division, several quotient bits a cycle
                for (int b = 0; b < DIV_RADIX_BITS; b++) begin
                    rem_ext = {rem_v, quo_v[QP-1]};
                    quo_v   = {quo_v[QP-2:0], 1'b0};
                    if (rem_ext >= {1'b0, r_div}) begin
                        rem_ext  = rem_ext - {1'b0, r_div};
                        quo_v[0] = 1'b1;
                    end
                    rem_v = rem_ext[DIV_W-1:0];
                end
                n_quo = quo_v;
                n_rem = rem_v;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SW'(STEPS - 1)) begin
                    n_state = M_SAT;
                end
            end
            M_SAT: begin
                n_sat   = sat_c;
                n_value = sat_c ? (r_neg ? SAT_MIN : SAT_MAX)
                                : (r_neg ? -$signed(r_quo[DATA_W-1:0])
                                         : $signed(r_quo[DATA_W-1:0]));
                n_done  = 1'b1;
                n_state = M_IDLE;
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_a <= n_mag_a;
        r_mag_b <= n_mag_b;
        r_neg   <= n_neg;
        r_rad   <= n_rad;
        r_div   <= n_div;
        r_prod  <= n_prod;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_value    = r_value;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == M_IDLE))
        else $error("muldiv started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("muldiv done held longer than one cycle");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

endmodule

// ===== src/taylor_series_sin_cos_exp.sv =====
// Work: sine/cosine use the shared multiply-divide unit once for the degree conversion, then
//   twice per term after the first; the exponential uses it once per term after the first,
//   with the term count clamped to MAX_TERMS (0 counts as 1).
// Throughput: one word at a time; the input is ready only while the sequencer is idle.
//   The result register lets the next word in while a result still waits downstream.
// Reset: synchronous, active low; clears the sequencer, the unit and the output valid.
module taylor_series_sin_cos_exp #(
    parameter int MAX_TERMS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tss_in_if.sink     i_in,
    tss_out_if.source  o_out
);
    import tss_pkg::*;

    localparam int KW = $clog2(MAX_TERMS + 1);
    localparam int CW = (KW > TERM_W) ? KW : TERM_W;
    localparam int DW = $clog2(2 * MAX_TERMS + 1);
    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_ISSUE = 6'b000100,
        S_WAIT  = 6'b001000,
        S_SUM   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Which multiply-divide the shared unit is doing
    typedef enum logic [3:0] {
        OP_RAD = 4'b0001,   // degrees to radians
        OP_TRM = 4'b0010,   // -t * r / i
        OP_TRT = 4'b0100,   // m * r / (i+1)
        OP_EXP = 4'b1000    // t * x / k
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [ACTION_W-1:0] r_act, n_act;
    logic [KW-1:0] r_n, n_n, r_k, n_k, n_clamp;
    logic [DW-1:0] r_i, n_i;
    logic signed [DATA_W-1:0] r_arg, n_arg, r_r, n_r, r_t, n_t, r_m, n_m, r_s, n_s;
    logic r_ov, n_ov;
    logic r_out_valid, n_out_valid, r_out_ov, n_out_ov;
    logic signed [DATA_W-1:0] r_out_sum, n_out_sum;

    logic is_trig, out_free, sum_ov;
    logic [DATA_W:0] sum_ext;
    logic signed [DATA_W-1:0] sum_val;

    t_md_req md_req;
    t_md_rsp md_rsp;
    logic signed [DATA_W-1:0] md_a, md_b, md_value;
    logic [DW-1:0] md_div;

    assign is_trig  = (r_act == ACT_SIN) || (r_act == ACT_COS);
    assign out_free = !r_out_valid || o_out.ready;

    // Clamp the term count to the largest the counters support
    assign n_clamp = (CW'(i_in.term_count) > CW'(MAX_TERMS)) ? KW'(MAX_TERMS)
                                                              : KW'(i_in.term_count);

    // Running sum with saturation
    assign sum_ext = {r_s[DATA_W-1], r_s} + {r_t[DATA_W-1], r_t};
    assign sum_ov  = sum_ext[DATA_W] ^ sum_ext[DATA_W-1];
    assign sum_val = sum_ov ? (sum_ext[DATA_W] ? SAT_MIN : SAT_MAX)
                            : $signed(sum_ext[DATA_W-1:0]);

    // Operand selection for the shared unit
    always_comb begin
        md_req.start    = (r_state == S_ISSUE);
        md_req.rad      = (r_op == OP_RAD);
        md_req.negate_a = (r_op == OP_TRM);
        unique case (r_op)
            OP_RAD: begin
                md_a   = r_arg;
                md_b   = DEG_TO_RAD_Q32;
                md_div = DW'(1);
            end
            OP_TRM: begin
                md_a   = r_t;
                md_b   = r_r;
                md_div = r_i;
            end
            OP_TRT: begin
                md_a   = r_m;
                md_b   = r_r;
                md_div = DW'(r_i + 1'b1);
            end
            OP_EXP: begin
                md_a   = r_t;
                md_b   = r_arg;
                md_div = DW'(r_k);
            end
            default: begin
                md_a   = '0;
                md_b   = '0;
                md_div = DW'(1);
            end
        endcase
    end

    tss_muldiv #(
        .FRAC_BITS (FRAC_BITS),
        .DIV_W     (DW)
    ) u_muldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (md_req),
        .i_op_a    (md_a),
        .i_op_b    (md_b),
        .i_divisor (md_div),
        .o_rsp     (md_rsp),
        .o_value   (md_value)
    );

    // Sequencer: one word at a time, each term built from the one before
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_act       = r_act;
        n_n         = r_n;
        n_k         = r_k;
        n_i         = r_i;
        n_arg       = r_arg;
        n_r         = r_r;
        n_t         = r_t;
        n_m         = r_m;
        n_s         = r_s;
        n_ov        = r_ov;
        n_out_sum   = r_out_sum;
        n_out_ov    = r_out_ov;
        n_out_valid = r_out_valid && !o_out.ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_act = i_in.action;
                    n_arg = i_in.argument;
                    n_n   = n_clamp;
                    n_ov  = 1'b0;
                    n_k   = KW'(1);
                    if ((i_in.action == ACT_SIN) || (i_in.action == ACT_COS)) begin
                        // convert to radians first
                        n_op    = OP_RAD;
                        n_state = S_ISSUE;
                    end else if (i_in.action == ACT_EXP) begin
                        n_t     = ONE;
                        n_s     = ONE;
                        n_state = S_CHECK;
                    end else begin
                        // unused select: answer zero
                        n_s     = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_CHECK: begin
                if (r_k < r_n) begin
                    n_op    = is_trig ? OP_TRM : OP_EXP;
                    n_state = S_ISSUE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ISSUE: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (md_rsp.done) begin
                    n_ov = r_ov | md_rsp.sat;
                    unique case (r_op)
                        OP_RAD: begin
                            n_r     = md_value;
                            n_t     = (r_act == ACT_SIN) ? md_value : ONE;
                            n_s     = (r_act == ACT_SIN) ? md_value : ONE;
                            n_i     = (r_act == ACT_SIN) ? DW'(2) : DW'(1);
                            n_state = S_CHECK;
                        end
                        OP_TRM: begin
                            n_m     = md_value;
                            n_op    = OP_TRT;
                            n_state = S_ISSUE;
                        end
                        default: begin
                            n_t     = md_value;
                            n_state = S_SUM;
                        end
                    endcase
                end
            end
            S_SUM: begin
                n_s     = sum_val;
                n_ov    = r_ov | sum_ov;
                n_k     = r_k + 1'b1;
                n_i     = is_trig ? DW'(r_i + 2'd2) : r_i;
                n_state = S_CHECK;
            end
            S_DONE: begin
                // hold until the result register frees up
                if (out_free) begin
                    n_out_sum   = r_s;
                    n_out_ov    = r_ov;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_RAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_n       <= n_n;
        r_k       <= n_k;
        r_i       <= n_i;
        r_arg     <= n_arg;
        r_r       <= n_r;
        r_t       <= n_t;
        r_m       <= n_m;
        r_s       <= n_s;
        r_ov      <= n_ov;
        r_out_sum <= n_out_sum;
        r_out_ov  <= n_out_ov;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.series_sum    = r_out_sum;
    assign o_out.overflow_flag = r_out_ov;

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second word taken while one is in flight");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == S_WAIT))
        else $error("unit result arrived outside the wait state");

    // a term count of zero starts the counter one above it
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> ((r_k <= r_n) || (r_k == KW'(1))))
        else $error("term counter ran past the term count");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free) |=> (o_out.valid && (r_state == S_IDLE)))
        else $error("result not presented on completion");

endmodule

// ===== bench/taylor_series_sin_cos_exp_tb.sv =====
module taylor_series_sin_cos_exp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int MAX_TERMS     = 32;
    localparam int FRAC          = 16;
    localparam int Q_ONE         = 1 << FRAC;
    localparam int RANDOM_WORDS  = 1525;
    // Worst case is a 32-term sine or cosine
    localparam int SETTLE_CYCLES = 1100;
    localparam int LONG_HOLD     = 2500;

    // The fourth select code has no function behind it; the block answers zero
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0]      action;
        logic [TERM_W-1:0]        term_count;
        logic signed [DATA_W-1:0] argument;
        bit                       drain_first;  // hold this word until all results are back
    } series_word_t;

    typedef struct {
        logic signed [DATA_W-1:0] sum;
        logic                     overflow;
    } series_result_t;

    typedef enum int { SINK_OPEN, SINK_RANDOM, SINK_SPARSE } sink_mode_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Source side of the input channel, driven only from the driver below
    logic                      src_valid    = 1'b0;
    logic [ACTION_W-1:0]       src_action   = '0;
    logic [TERM_W-1:0]         src_terms    = '0;
    logic signed [DATA_W-1:0]  src_argument = '0;
    logic                      sink_ready   = 1'b0;

    tss_in_if  in_word ();
    tss_out_if out_word ();

    assign in_word.valid      = src_valid;
    assign in_word.action     = src_action;
    assign in_word.term_count = src_terms;
    assign in_word.argument   = src_argument;
    assign out_word.ready     = sink_ready;

    taylor_series_sin_cos_exp #(
        .MAX_TERMS(MAX_TERMS),
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_word),
        .o_out  (out_word)
    );

    series_word_t   pending_words[$];
    series_result_t expected_results[$];
    series_word_t   held_word;
    int             mismatch_count = 0;

    // ------------------------------------------------------------------
    // Series predictor
    // ------------------------------------------------------------------

    // round(a * b / den), halves away from zero, on the exact 64-bit product
    function automatic longint scaled_round(longint a, longint b, longint unsigned den);
        bit               neg;
        longint unsigned  mag_a;
        longint unsigned  mag_b;
        longint unsigned  quo;
        neg   = (a < 0) != (b < 0);
        mag_a = (a < 0) ? -a : a;
        mag_b = (b < 0) ? -b : b;
        quo   = (mag_a * mag_b + den / 2) / den;
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    // Clamp to the 32-bit range; remember that a clamp happened
    function automatic longint clamp_q(longint v, inout bit ovf);
        if (v > SAT_MAX) begin
            ovf = 1'b1;
            return SAT_MAX;
        end
        if (v < SAT_MIN) begin
            ovf = 1'b1;
            return SAT_MIN;
        end
        return v;
    endfunction

    function automatic series_result_t taylor_expect(series_word_t w);
        series_result_t res;
        longint         unit_q;
        longint         arg;
        longint         rad;
        longint         term;
        longint         mid;
        longint         acc;
        int unsigned    n;
        int unsigned    j;
        int unsigned    k;
        bit             ovf;
        unit_q = longint'(1) << FRAC;
        arg    = longint'(w.argument);
        n      = (w.term_count > MAX_TERMS) ? MAX_TERMS : w.term_count;
        ovf    = 1'b0;
        acc    = 0;
        if (w.action == ACT_SIN || w.action == ACT_COS) begin
            // Degrees to radians with the Q0.32 factor
            rad = scaled_round(arg, longint'(DEG_TO_RAD_Q32), 64'd1 << 32);
            if (w.action == ACT_SIN) begin
                term = rad;
                k    = 2;
            end else begin
                term = unit_q;
                k    = 1;
            end
            acc = term;
            for (j = 2; j <= n; j++) begin
                // Each term comes from the last: times -r/k, then times r/(k+1)
                mid  = clamp_q(scaled_round(-term, rad, longint'(k) << FRAC), ovf);
                term = clamp_q(scaled_round(mid, rad, longint'(k + 1) << FRAC), ovf);
                acc  = clamp_q(acc + term, ovf);
                k   += 2;
            end
        end else if (w.action == ACT_EXP) begin
            term = unit_q;
            acc  = unit_q;
            for (j = 1; j < n; j++) begin
                term = clamp_q(scaled_round(term, arg, longint'(j) << FRAC), ovf);
                acc  = clamp_q(acc + term, ovf);
            end
        end
        res.sum      = acc[DATA_W-1:0];
        res.overflow = ovf;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic signed [DATA_W-1:0] deg_q(int d);
        return d * Q_ONE;
    endfunction

    function automatic series_word_t make_word(logic [ACTION_W-1:0] act, int terms,
                                               logic signed [DATA_W-1:0] arg, bit drain);
        series_word_t w;
        w.action      = act;
        w.term_count  = TERM_W'(terms);
        w.argument    = arg;
        w.drain_first = drain;
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_argument();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return int'($urandom_range(0, 1440 * Q_ONE)) - 720 * Q_ONE;
            4, 5:       return int'($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE;
            6, 7:       return $urandom();
            8: begin
                case ($urandom_range(0, 4))
                    0:       return SAT_MAX;
                    1:       return SAT_MIN;
                    2:       return '0;
                    3:       return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            default:    return int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
        endcase
    endfunction

    // Mostly short series; long ones, and counts past the clamp, now and then
    function automatic int random_terms();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return $urandom_range(0, 8);
        else if (pick < 9)
            return $urandom_range(9, 20);
        return $urandom_range(21, 63);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver: offer words in bursts, hold each until the block takes it
    // ------------------------------------------------------------------

    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_valid <= 1'b0;
        end else begin
            // A word taken at this edge gets its expected result queued now
            if (src_valid && in_word.ready)
                expected_results.push_back(taylor_expect(held_word));

            if (src_valid && !in_word.ready) begin
                // hold the current word
            end else if (gap_left > 0) begin
                gap_left--;
                src_valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
                src_valid <= 1'b0;
            end else if (pending_words[0].drain_first && expected_results.size() != 0) begin
                // Pause until every outstanding result has come back
                src_valid <= 1'b0;
            end else begin
                held_word     = pending_words.pop_front();
                src_action   <= held_word.action;
                src_terms    <= held_word.term_count;
                src_argument <= held_word.argument;
                src_valid    <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, with two long hold-offs
    // ------------------------------------------------------------------

    sink_mode_t sink_mode    = SINK_OPEN;
    int         stretch_left = 0;
    int         hold_left    = 0;
    int         taken_count  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (out_word.valid && out_word.ready)
                taken_count++;

            if (hold_left > 0) begin
                hold_left--;
                sink_ready <= 1'b0;
            end else if (out_word.valid && out_word.ready
                         && (taken_count == 100 || taken_count == 900)) begin
                // Drop ready for a long stretch so the block backs up into its input
                hold_left = LONG_HOLD;
                sink_ready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    sink_mode    = sink_mode_t'($urandom_range(0, 2));
                    stretch_left = $urandom_range(20, 200);
                end else begin
                    stretch_left--;
                end
                case (sink_mode)
                    SINK_OPEN:   sink_ready <= 1'b1;
                    SINK_RANDOM: sink_ready <= $urandom_range(0, 1);
                    default:     sink_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every result taken with the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        series_result_t want;
        if (i_rst_n && out_word.valid && out_word.ready) begin
            if (expected_results.size() == 0) begin
                $error("series_sum: expected nothing, got %0d", out_word.series_sum);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_word.series_sum !== want.sum) begin
                    $error("series_sum: expected %0d, got %0d", want.sum, out_word.series_sum);
                    mismatch_count++;
                end
                if (out_word.overflow_flag !== want.overflow) begin
                    $error("overflow_flag: expected %0b, got %0b",
                           want.overflow, out_word.overflow_flag);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: fill the word queue, release reset, wait for drain
    // ------------------------------------------------------------------

    initial begin
        int                  idx;
        logic [ACTION_W-1:0] act;

        // Directed words: zero and one term, clamped counts, overflow, extreme arguments
        pending_words.push_back(make_word(ACT_SIN, 0, '0, 1'b0));
        pending_words.push_back(make_word(ACT_SIN, 1, deg_q(90), 1'b0));
        pending_words.push_back(make_word(ACT_SIN, 8, deg_q(30), 1'b0));
        pending_words.push_back(make_word(ACT_SIN, 32, deg_q(90), 1'b0));
        pending_words.push_back(make_word(ACT_SIN, 63, deg_q(180), 1'b0));
        pending_words.push_back(make_word(ACT_SIN, 12, deg_q(-45), 1'b0));
        pending_words.push_back(make_word(ACT_COS, 0, deg_q(60), 1'b0));
        pending_words.push_back(make_word(ACT_COS, 1, deg_q(60), 1'b0));
        pending_words.push_back(make_word(ACT_COS, 10, deg_q(60), 1'b0));
        pending_words.push_back(make_word(ACT_COS, 33, deg_q(-360), 1'b0));
        pending_words.push_back(make_word(ACT_EXP, 0, Q_ONE, 1'b1));
        pending_words.push_back(make_word(ACT_EXP, 1, Q_ONE, 1'b0));
        pending_words.push_back(make_word(ACT_EXP, 20, Q_ONE, 1'b0));
        pending_words.push_back(make_word(ACT_EXP, 32, -4 * Q_ONE, 1'b0));
        pending_words.push_back(make_word(ACT_EXP, 32, 20 * Q_ONE, 1'b0));
        pending_words.push_back(make_word(ACT_EXP, 5, SAT_MAX, 1'b0));
        pending_words.push_back(make_word(ACT_EXP, 3, SAT_MIN, 1'b0));
        pending_words.push_back(make_word(ACT_SIN, 32, SAT_MAX, 1'b0));
        pending_words.push_back(make_word(ACT_SIN, 4, SAT_MIN, 1'b0));
        pending_words.push_back(make_word(ACT_COS, 32, SAT_MAX, 1'b0));
        pending_words.push_back(make_word(ACT_COS, 6, 32'sd1, 1'b0));
        pending_words.push_back(make_word(ACT_EXP, 9, -32'sd1, 1'b0));
        pending_words.push_back(make_word(ACT_UNUSED, 32, deg_q(45), 1'b0));
        pending_words.push_back(make_word(ACT_UNUSED, 0, SAT_MIN, 1'b0));

        // Random words; the unused select turns up now and then
        for (idx = 0; idx < RANDOM_WORDS; idx++) begin
            act = ($urandom_range(0, 24) == 0) ? ACT_UNUSED : ACTION_W'($urandom_range(0, 2));
            pending_words.push_back(make_word(act, random_terms(), random_argument(),
                                              idx == 700));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word is taken and every result is back
        while (pending_words.size() != 0 || src_valid || expected_results.size() != 0)
            @(posedge i_clk);

        // Let any stray result show itself
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("taylor_series_sin_cos_exp_tb: done, clean");
        else
            $display("taylor_series_sin_cos_exp_tb: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #200_000_000;
        $display("taylor_series_sin_cos_exp_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/tss_pkg.sv
src/tss_if.sv
src/tss_muldiv.sv
src/taylor_series_sin_cos_exp.sv
bench/taylor_series_sin_cos_exp_tb.sv
